// ===== sv/rcl_pkg.sv =====
// Shared constants and types for the ray length clamp.
// No dependencies; imported by every rcl_* module and the top level.
package rcl_pkg;

  localparam int LEN_W  = 31;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef logic [LEN_W-1:0] len_t;

endpackage

// ===== sv/clip_ray_to_max_length_top.sv =====
// Ray length clamp, top level: config register, front end, queue, back end.
// Depends on rcl_pkg, rcl_front, rcl_queue, rcl_back.
//
// Usage: each in_ beat carries one ray (start and end points, signed fixed
// point). If the length limit is nonzero and the ray is longer, the end point
// is pulled in to the limit from the start and out_tuser is set; otherwise
// the end point passes unchanged. The limit is loaded through
// cfg_wen/cfg_wdata while the block is idle; zero disables clipping.
// Throughput: one ray per cycle, fully pipelined, while out_tready is high.
// The square root and divide stages resolve one bit per stage.
// Reset clears all valid bits and the limit; nothing else needs clearing.
// When out_tready is low the back pipeline holds; the front keeps accepting
// until a four-entry queue between the two fills, then in_tready drops.
module clip_ray_to_max_length_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wen,
  input  rcl_pkg::len_t               cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_end_x, out_end_y, out_end_z (lowest first)
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // clipped
  output logic                        out_tuser
);
  import rcl_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = 6*CW + 4 + 3*(CW + 1 + LEN_W) + 2*CW + 2;
  localparam int OTDW = ((3*CW+7)/8)*8;

  len_t max_len_r;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [IW-1:0] f_item, b_item;
  logic [3*CW-1:0] coord;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '0;
    end else if (cfg_wen) begin
      max_len_r <= cfg_wdata;
    end
  end

  rcl_front #(.CW(CW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .max_len (max_len_r),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_data (in_tdata[6*CW-1:0]),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_item  (f_item)
  );

  rcl_queue #(.W(IW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data (f_item),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_data (b_item)
  );

  rcl_back #(.CW(CW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .b_valid  (b_valid),
    .b_ready  (b_ready),
    .b_item   (b_item),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_coord(coord),
    .out_clip (out_tuser)
  );

  assign out_tdata = OTDW'(coord);

endmodule

// ===== sv/rcl_front.sv =====
// Front end: difference vector, squares, products with the length limit, clip decision.
// Depends on rcl_pkg.
module rcl_front #(
  parameter int CW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rcl_pkg::len_t         max_len,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [6*CW-1:0]       in_data,
  output logic                  f_valid,
  input  logic                  f_ready,
  output logic [6*CW+4+3*(CW+1+rcl_pkg::LEN_W)+2*CW+1:0] f_item
);
  import rcl_pkg::*;

  localparam int MW   = CW + 1;
  localparam int PW   = MW + LEN_W;
  localparam int L2W  = 2 * CW + 2;
  localparam int MMW  = 2 * LEN_W;
  localparam int CMPW = (L2W > MMW) ? L2W : MMW;

  logic adv;
  logic v1_r, v2_r, v3_r;
  logic [CW-1:0]  s1_r [3];
  logic [CW-1:0]  e1_r [3];
  logic [MW-1:0]  mag1_r [3];
  logic [2:0]     neg1_r;
  logic [CW-1:0]  s2_r [3];
  logic [CW-1:0]  e2_r [3];
  logic [2:0]     neg2_r;
  logic [L2W-1:0] sq2_r [3];
  logic [PW-1:0]  prod2_r [3];
  logic [MMW-1:0] mm2_r;
  logic [CW-1:0]  s3_r [3];
  logic [CW-1:0]  e3_r [3];
  logic [2:0]     neg3_r;
  logic [PW-1:0]  prod3_r [3];
  logic [L2W-1:0] l2_3_r;
  logic           clip3_r;
  logic [L2W-1:0] l2_sum;
  logic [CMPW-1:0] l2_ext, mm_ext;

  assign adv      = !v3_r || f_ready;
  assign in_ready = adv;
  assign f_valid  = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [CW-1:0] s_in, e_in;
    logic [CW:0]   dif;
    assign s_in = in_data[k*CW +: CW];
    assign e_in = in_data[(k+3)*CW +: CW];
    assign dif  = {e_in[CW-1], e_in} - {s_in[CW-1], s_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        s1_r[k]    <= s_in;
        e1_r[k]    <= e_in;
        neg1_r[k]  <= dif[CW];
        mag1_r[k]  <= dif[CW] ? (~dif + 1'b1) : dif;
        s2_r[k]    <= s1_r[k];
        e2_r[k]    <= e1_r[k];
        neg2_r[k]  <= neg1_r[k];
        sq2_r[k]   <= mag1_r[k] * mag1_r[k];
        prod2_r[k] <= mag1_r[k] * max_len;
        s3_r[k]    <= s2_r[k];
        e3_r[k]    <= e2_r[k];
        neg3_r[k]  <= neg2_r[k];
        prod3_r[k] <= prod2_r[k];
      end
    end

    assign f_item[k*CW +: CW]            = s3_r[k];
    assign f_item[(k+3)*CW +: CW]        = e3_r[k];
    assign f_item[6*CW + k]              = neg3_r[k];
    assign f_item[6*CW+4+k*PW +: PW]     = prod3_r[k];
  end

  assign l2_sum = sq2_r[0] + sq2_r[1] + sq2_r[2];
  assign l2_ext = CMPW'(l2_sum);
  assign mm_ext = CMPW'(mm2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      mm2_r   <= max_len * max_len;
      l2_3_r  <= l2_sum;
      clip3_r <= (max_len != '0) && (l2_ext > mm_ext);
    end
  end

  assign f_item[6*CW+3]             = clip3_r;
  assign f_item[6*CW+4+3*PW +: L2W] = l2_3_r;

endmodule

// ===== sv/rcl_queue.sv =====
// Short register queue between the front and back ends.
// Depends on rcl_pkg.
module rcl_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  import rcl_pkg::*;

  logic [W-1:0]   mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop;

  assign wr_ready = cnt_r != (QAW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r == $past(cnt_r) + $past(push) - $past(pop))
    else $error("queue count mismatch");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QAW'(wp_r - rp_r) == cnt_r[QAW-1:0]) else $error("queue pointers out of step");

endmodule

// ===== sv/rcl_back.sv =====
// Back end: pipelined integer square root, three pipelined dividers, saturation.
// Depends on rcl_pkg.
module rcl_back #(
  parameter int CW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            b_valid,
  output logic            b_ready,
  input  logic [6*CW+4+3*(CW+1+rcl_pkg::LEN_W)+2*CW+1:0] b_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3*CW-1:0] out_coord,
  output logic            out_clip
);
  import rcl_pkg::*;

  localparam int SW  = CW + 1;
  localparam int RW  = SW + 2;
  localparam int L2W = 2 * SW;
  localparam int QW  = CW + 1;
  localparam int PW  = CW + 1 + LEN_W;
  localparam int NW  = PW + 1;
  localparam int C2W = 6 * CW + 4;
  localparam int CXW = C2W + 3 * PW;

  logic adv;
  logic ov_r;

  assign adv     = !ov_r || out_ready;
  assign b_ready = adv;

  // square root stages
  logic [RW-1:0]  s_rem  [SW+1];
  logic [SW-1:0]  s_root [SW+1];
  logic [L2W-1:0] s_rad  [SW+1];
  logic [CXW-1:0] s_ctx  [SW+1];
  logic [SW:0]    s_vld;

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_rad[0]  = b_item[CXW +: L2W];
  assign s_ctx[0]  = b_item[CXW-1:0];
  assign s_vld[0]  = b_valid;

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [RW-1:0] cur, trial;
    logic          ge;
    assign cur   = {s_rem[j][RW-3:0], s_rad[j][L2W-1 -: 2]};
    assign trial = {s_root[j], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld[j+1] <= 1'b0;
      end else if (adv) begin
        s_vld[j+1] <= s_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_rem[j+1]  <= ge ? (cur - trial) : cur;
        s_root[j+1] <= {s_root[j][SW-2:0], ge};
        s_rad[j+1]  <= s_rad[j] << 2;
        s_ctx[j+1]  <= s_ctx[j];
      end
    end
  end

  // rounding offset stage and dividers
  logic [SW-1:0]  dv_s   [QW+1];
  logic [C2W-1:0] dv_ctx [QW+1];
  logic [QW:0]    dv_vld;
  logic [SW-1:0]  dv_rem [3][QW+1];
  logic [QW-1:0]  dv_lo  [3][QW+1];
  logic [QW-1:0]  dv_q   [3][QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= s_vld[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_s[0]   <= s_root[SW];
      dv_ctx[0] <= s_ctx[SW][C2W-1:0];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_num
    logic [NW-1:0] num, num_hi;
    assign num    = NW'(s_ctx[SW][C2W+k*PW +: PW]) + NW'(s_root[SW] >> 1);
    assign num_hi = num >> QW;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k][0] <= num_hi[SW-1:0];
        dv_lo[k][0]  <= num[QW-1:0];
        dv_q[k][0]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_s[j+1]   <= dv_s[j];
        dv_ctx[j+1] <= dv_ctx[j];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [SW:0] cur;
      logic        ge;
      assign cur = {dv_rem[k][j], dv_lo[k][j][QW-1]};
      assign ge  = cur >= {1'b0, dv_s[j]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[k][j+1] <= ge ? SW'(cur - {1'b0, dv_s[j]}) : cur[SW-1:0];
          dv_lo[k][j+1]  <= dv_lo[k][j] << 1;
          dv_q[k][j+1]   <= {dv_q[k][j][QW-2:0], ge};
        end
      end
    end
  end

  // output register
  logic [CW-1:0] oc_r [3];
  logic          oclip_r;
  logic          fin_clip;

  assign fin_clip = dv_ctx[QW][6*CW+3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) oclip_r <= fin_clip;
  end

  for (genvar k = 0; k < 3; k++) begin : g_out
    logic [CW-1:0] st, en;
    logic [CW+1:0] qx, sq, sum;
    logic [CW-1:0] sat;
    assign st  = dv_ctx[QW][k*CW +: CW];
    assign en  = dv_ctx[QW][(k+3)*CW +: CW];
    assign qx  = {1'b0, dv_q[k][QW]};
    assign sq  = dv_ctx[QW][6*CW+k] ? (~qx + 1'b1) : qx;
    assign sum = {{2{st[CW-1]}}, st} + sq;

    always_comb begin
      if (sum[CW+1] && !(sum[CW] && sum[CW-1])) begin
        sat = {1'b1, {(CW-1){1'b0}}};
      end else if (!sum[CW+1] && (sum[CW] || sum[CW-1])) begin
        sat = {1'b0, {(CW-1){1'b1}}};
      end else begin
        sat = sum[CW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) oc_r[k] <= fin_clip ? sat : en;
    end

    assign out_coord[k*CW +: CW] = oc_r[k];
  end

  assign out_valid = ov_r;
  assign out_clip  = oclip_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(s_vld[SW:1]) && $stable(dv_vld))
    else $error("pipeline moved under stall");
  a_noclip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oclip_r |-> $past(dv_s[QW]) != '0 || !$past(adv))
    else $error("clip with zero root");
  a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(adv) |-> ov_r == $past(dv_vld[QW]))
    else $error("output valid lost");

endmodule
